FILE: hw/rtl/mpsm_pkg.sv
// ---------------------------------------------------------------------------
// mpsm_pkg
// Constants, codes and types of the multi-pattern string matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package mpsm_pkg;

    localparam int NODES           = 1024;
    localparam int ALPHABET        = 26;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int MAX_RESULTS     = 32;

    localparam int GOTO_DEPTH = NODES * ALPHABET;
    localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
    localparam int NODE_AW    = $clog2(NODES);
    localparam int CNT_W      = NODE_AW + 1;
    localparam int DEPTH_W    = $clog2(MAX_PATTERN_LEN + 1);
    localparam int NRES_W     = $clog2(MAX_RESULTS + 1);
    localparam int SYM_W      = 5;
    localparam int PID_W      = 8;
    localparam int POS_W      = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_END    = 2'd1,
        OP_BUILD  = 2'd2,
        OP_SCAN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_BAD   = 2'd2,
        STS_PHASE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS,
        S_STAT,
        S_B_HEAD,
        S_B_U,
        S_B_FU,
        S_B_RV,
        S_B_RF,
        S_B_GT,
        S_B_LK,
        S_B_Q,
        S_SG,
        S_SN,
        S_LAST
    } state_t;

    // One word of the node memory
    typedef struct packed {
        logic [NODE_AW-1:0] queue;
        logic [PID_W-1:0]   pid;
        logic [NODE_AW-1:0] fail;
        logic [NODE_AW-1:0] outl;
    } node_t;

    // Goto memory address of a node's row and a letter
    function automatic logic [GOTO_AW-1:0] goto_addr(logic [NODE_AW-1:0] node,
                                                     logic [SYM_W-1:0] sym);
        return GOTO_AW'(node) * GOTO_AW'(ALPHABET) + GOTO_AW'(sym);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/multi_pattern_string_matcher.sv
// ---------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick matcher: trie load, breadth-first link build, text scan.
// ---------------------------------------------------------------------------
// After reset a clearing pass over all 26624 goto entries zeroes the memories;
// no transfer is taken meanwhile. Insert reads the goto entry, then follows or
// creates the edge and reports its status; scan steps the automaton, then walks
// the output-link chain. Build reads the goto entries of each trie node through
// the single read port of the goto memory.
// Reset (rst_n low, asynchronous) clears all control state.
`default_nettype none

module multi_pattern_string_matcher import mpsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // symbol[4:0], pattern_id[12:5], text_start[13]
    input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // status[1:0], match_id[9:2], position[41:10]
    output logic [0:0]       m_axis_tuser,  // kind[0]
    output logic             m_axis_tlast
);

    // Memories
    logic [NODE_AW-1:0] goto_mem [GOTO_DEPTH];
    node_t              node_mem [NODES];

    logic               goto_we, goto_re;
    logic [GOTO_AW-1:0] goto_waddr, goto_raddr;
    logic [NODE_AW-1:0] goto_wdata, goto_rd_reg;

    logic               node_we_pid, node_we_link, node_we_queue, node_re;
    logic [NODE_AW-1:0] node_waddr, node_raddr;
    node_t              node_wdata, node_rd_reg;

    // Control state
    state_t             state_reg, state_next;
    logic [GOTO_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [NODE_AW-1:0] cursor_reg, cursor_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    status_t            fault_reg, fault_next;
    logic               built_reg, built_next;
    logic [NODE_AW-1:0] scan_node_reg, scan_node_next;
    logic [POS_W-1:0]   text_pos_reg, text_pos_next;
    logic [POS_W-1:0]   scan_pos_reg, scan_pos_next;
    logic [NRES_W-1:0]  nres_reg, nres_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [PID_W-1:0]   hold_id_reg, hold_id_next;
    status_t            st_reg, st_next;
    logic [GOTO_AW-1:0] ins_addr_reg, ins_addr_next;
    logic [CNT_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [SYM_W-1:0]   i_reg, i_next;
    logic               root_reg, root_next;
    logic [GOTO_AW-1:0] u_base_reg, u_base_next, fu_base_reg, fu_base_next;
    logic [NODE_AW-1:0] v_reg, v_next, f_reg, f_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    status_t            out_status_reg, out_status_next;
    logic [PID_W-1:0]   out_id_reg, out_id_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic               out_last_reg, out_last_next;

    // Input fields
    op_t                in_op;
    logic [SYM_W-1:0]   in_sym;
    logic [PID_W-1:0]   in_pid;
    logic               in_start;

    logic               can_load, out_load, adv, match, stall;
    logic [NODE_AW-1:0] f_val, scan_from;
    logic [POS_W-1:0]   pos_val;
    logic [GOTO_AW-1:0] ins_addr;

    assign in_op    = op_t'(s_axis_tuser);
    assign in_sym   = s_axis_tdata[4:0];
    assign in_pid   = s_axis_tdata[12:5];
    assign in_start = s_axis_tdata[13];

    assign can_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_pos_reg, out_id_reg, out_status_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    assign scan_from = in_start ? '0 : scan_node_reg;
    assign pos_val   = in_start ? '0 : text_pos_reg;
    assign ins_addr  = goto_addr(cursor_reg, in_sym);
    assign f_val     = root_reg ? '0 : goto_rd_reg;
    assign match     = (node_rd_reg.pid != '0) && (nres_reg < NRES_W'(MAX_RESULTS));
    assign stall     = match && hold_valid_reg && !can_load;

    // Next state, memory controls and results
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        depth_next      = depth_reg;
        fault_next      = fault_reg;
        built_next      = built_reg;
        scan_node_next  = scan_node_reg;
        text_pos_next   = text_pos_reg;
        scan_pos_next   = scan_pos_reg;
        nres_next       = nres_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        st_next         = st_reg;
        ins_addr_next   = ins_addr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        i_next          = i_reg;
        root_next       = root_reg;
        u_base_next     = u_base_reg;
        fu_base_next    = fu_base_reg;
        v_next          = v_reg;
        f_next          = f_reg;

        goto_we       = 1'b0;
        goto_re       = 1'b0;
        goto_waddr    = '0;
        goto_raddr    = '0;
        goto_wdata    = '0;
        node_we_pid   = 1'b0;
        node_we_link  = 1'b0;
        node_we_queue = 1'b0;
        node_re       = 1'b0;
        node_waddr    = '0;
        node_raddr    = '0;
        node_wdata    = '0;

        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        adv             = 1'b0;

        unique case (state_reg)
            // Zero both memories, one entry a cycle
            S_CLEAR:
            begin
                goto_we    = 1'b1;
                goto_waddr = clr_reg;
                if (clr_reg < GOTO_AW'(NODES))
                begin
                    node_we_pid   = 1'b1;
                    node_we_link  = 1'b1;
                    node_we_queue = 1'b1;
                    node_waddr    = clr_reg[NODE_AW-1:0];
                end
                if (clr_reg == GOTO_AW'(GOTO_DEPTH - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end

            // Take one transfer and dispatch on the operation
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (in_op)
                        OP_INSERT:
                        begin
                            state_next = S_STAT;
                            priority if (built_reg)
                                st_next = STS_PHASE;
                            else if (fault_reg != STS_OK)
                                st_next = fault_reg;
                            else if (in_sym >= SYM_W'(ALPHABET) ||
                                     depth_reg >= DEPTH_W'(MAX_PATTERN_LEN))
                            begin
                                fault_next = STS_BAD;
                                st_next    = STS_BAD;
                            end
                            else
                            begin
                                goto_re       = 1'b1;
                                goto_raddr    = ins_addr;
                                ins_addr_next = ins_addr;
                                state_next    = S_INS;
                            end
                        end
                        OP_END:
                        begin
                            state_next = S_STAT;
                            priority if (built_reg)
                                st_next = STS_PHASE;
                            else
                            begin
                                priority if (fault_reg != STS_OK)
                                    st_next = fault_reg;
                                else if (depth_reg == '0)
                                    st_next = STS_BAD;
                                else
                                begin
                                    node_we_pid    = 1'b1;
                                    node_waddr     = cursor_reg;
                                    node_wdata.pid = in_pid;
                                    st_next        = STS_OK;
                                end
                                cursor_next = '0;
                                depth_next  = '0;
                                fault_next  = STS_OK;
                            end
                        end
                        OP_BUILD:
                        begin
                            if (built_reg)
                            begin
                                st_next    = STS_PHASE;
                                state_next = S_STAT;
                            end
                            else
                            begin
                                cursor_next  = '0;
                                depth_next   = '0;
                                fault_next   = STS_OK;
                                head_next    = '0;
                                tail_next    = '0;
                                i_next       = '0;
                                root_next    = 1'b1;
                                u_base_next  = '0;
                                fu_base_next = '0;
                                state_next   = S_B_RV;
                            end
                        end
                        OP_SCAN:
                        begin
                            if (!built_reg)
                            begin
                                st_next    = STS_PHASE;
                                state_next = S_STAT;
                            end
                            else
                            begin
                                scan_pos_next = pos_val;
                                text_pos_next = pos_val + 1'b1;
                                nres_next     = '0;
                                if (in_sym >= SYM_W'(ALPHABET))
                                    scan_node_next = '0;
                                else
                                begin
                                    goto_re    = 1'b1;
                                    goto_raddr = goto_addr(scan_from, in_sym);
                                    state_next = S_SG;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Follow or create the trie edge
            S_INS:
            begin
                state_next = S_STAT;
                if (goto_rd_reg == '0 && count_reg >= CNT_W'(NODES))
                begin
                    fault_next = STS_FULL;
                    st_next    = STS_FULL;
                end
                else
                begin
                    if (goto_rd_reg == '0)
                    begin
                        goto_we     = 1'b1;
                        goto_waddr  = ins_addr_reg;
                        goto_wdata  = count_reg[NODE_AW-1:0];
                        cursor_next = count_reg[NODE_AW-1:0];
                        count_next  = count_reg + 1'b1;
                    end
                    else
                        cursor_next = goto_rd_reg;
                    depth_next = depth_reg + 1'b1;
                    st_next    = STS_OK;
                end
            end

            // Hand the status result to the output register
            S_STAT:
            begin
                if (can_load)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = 1'b0;
                    out_status_next = st_reg;
                    out_id_next     = '0;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // Fetch the next queued node or finish the build
            S_B_HEAD:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                    st_next    = STS_OK;
                    state_next = S_STAT;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = head_reg[NODE_AW-1:0];
                    state_next = S_B_U;
                end
            end

            S_B_U:
            begin
                u_base_next = goto_addr(node_rd_reg.queue, '0);
                node_re     = 1'b1;
                node_raddr  = node_rd_reg.queue;
                state_next  = S_B_FU;
            end

            S_B_FU:
            begin
                fu_base_next = goto_addr(node_rd_reg.fail, '0);
                i_next       = '0;
                state_next   = S_B_RV;
            end

            // Read the node's own goto entry
            S_B_RV:
            begin
                goto_re    = 1'b1;
                goto_raddr = u_base_reg + GOTO_AW'(i_reg);
                state_next = S_B_RF;
            end

            // Read the failure node's goto entry
            S_B_RF:
            begin
                v_next     = goto_rd_reg;
                goto_re    = 1'b1;
                goto_raddr = fu_base_reg + GOTO_AW'(i_reg);
                state_next = S_B_GT;
            end

            // Fill a missing edge below the root or go on to link the child
            S_B_GT:
            begin
                f_next = f_val;
                if (v_reg == '0)
                begin
                    if (!root_reg)
                    begin
                        goto_we    = 1'b1;
                        goto_waddr = u_base_reg + GOTO_AW'(i_reg);
                        goto_wdata = f_val;
                    end
                    adv = 1'b1;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = f_val;
                    state_next = S_B_LK;
                end
            end

            // Write failure and dictionary-suffix links of the child
            S_B_LK:
            begin
                node_we_link    = 1'b1;
                node_waddr      = v_reg;
                node_wdata.fail = f_reg;
                node_wdata.outl = (node_rd_reg.pid != '0) ? f_reg : node_rd_reg.outl;
                state_next      = S_B_Q;
            end

            // Enqueue the child
            S_B_Q:
            begin
                if (tail_reg < CNT_W'(NODES))
                begin
                    node_we_queue    = 1'b1;
                    node_waddr       = tail_reg[NODE_AW-1:0];
                    node_wdata.queue = v_reg;
                    tail_next        = tail_reg + 1'b1;
                end
                adv = 1'b1;
            end

            // Step the automaton
            S_SG:
            begin
                scan_node_next = goto_rd_reg;
                if (goto_rd_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = goto_rd_reg;
                    state_next = S_SN;
                end
            end

            // Walk the output-link chain, holding back one match
            S_SN:
            begin
                if (!stall)
                begin
                    if (match)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_load        = 1'b1;
                            out_kind_next   = 1'b1;
                            out_status_next = STS_OK;
                            out_id_next     = hold_id_reg;
                            out_pos_next    = scan_pos_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_id_next    = node_rd_reg.pid;
                        nres_next       = nres_reg + 1'b1;
                    end
                    priority if (node_rd_reg.outl != '0)
                    begin
                        node_re    = 1'b1;
                        node_raddr = node_rd_reg.outl;
                    end
                    else if (match || hold_valid_reg)
                        state_next = S_LAST;
                    else
                        state_next = S_IDLE;
                end
            end

            // Send the held match as the final one
            S_LAST:
            begin
                if (can_load)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = 1'b1;
                    out_status_next = STS_OK;
                    out_id_next     = hold_id_reg;
                    out_pos_next    = scan_pos_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // Advance to the next letter or the next queued node
        if (adv)
        begin
            if (i_reg == SYM_W'(ALPHABET - 1))
            begin
                if (root_reg)
                    root_next = 1'b0;
                else
                    head_next = head_reg + 1'b1;
                state_next = S_B_HEAD;
            end
            else
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_B_RV;
            end
        end

        // Output register handshake
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Goto memory
    always_ff @(posedge clk)
    begin
        if (goto_we)
            goto_mem[goto_waddr] <= goto_wdata;
        if (goto_re)
            goto_rd_reg <= goto_mem[goto_raddr];
    end

    // Node memory with field write enables
    always_ff @(posedge clk)
    begin
        if (node_we_pid)
            node_mem[node_waddr].pid <= node_wdata.pid;
        if (node_we_link)
        begin
            node_mem[node_waddr].fail <= node_wdata.fail;
            node_mem[node_waddr].outl <= node_wdata.outl;
        end
        if (node_we_queue)
            node_mem[node_waddr].queue <= node_wdata.queue;
        if (node_re)
            node_rd_reg <= node_mem[node_raddr];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            count_reg      <= CNT_W'(1);
            cursor_reg     <= '0;
            depth_reg      <= '0;
            fault_reg      <= STS_OK;
            built_reg      <= 1'b0;
            scan_node_reg  <= '0;
            text_pos_reg   <= '0;
            scan_pos_reg   <= '0;
            nres_reg       <= '0;
            hold_valid_reg <= 1'b0;
            hold_id_reg    <= '0;
            st_reg         <= STS_OK;
            ins_addr_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            i_reg          <= '0;
            root_reg       <= 1'b0;
            u_base_reg     <= '0;
            fu_base_reg    <= '0;
            v_reg          <= '0;
            f_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_status_reg <= STS_OK;
            out_id_reg     <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            depth_reg      <= depth_next;
            fault_reg      <= fault_next;
            built_reg      <= built_next;
            scan_node_reg  <= scan_node_next;
            text_pos_reg   <= text_pos_next;
            scan_pos_reg   <= scan_pos_next;
            nres_reg       <= nres_next;
            hold_valid_reg <= hold_valid_next;
            hold_id_reg    <= hold_id_next;
            st_reg         <= st_next;
            ins_addr_reg   <= ins_addr_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            i_reg          <= i_next;
            root_reg       <= root_next;
            u_base_reg     <= u_base_next;
            fu_base_reg    <= fu_base_next;
            v_reg          <= v_next;
            f_reg          <= f_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_pos_reg    <= out_pos_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb_multi_pattern_string_matcher.sv
// ---------------------------------------------------------------------------
// tb_multi_pattern_string_matcher
// Self-checking bench for the Aho-Corasick string matcher.
// ---------------------------------------------------------------------------
// Loads a trie (directed cases, a short chain of nested a-patterns, one
// pattern that runs too long, then overlapping random patterns), builds the
// links, then scans random text. A local automaton predicts every status and
// match transfer, and the monitor compares each one in order. Both sides of
// the stream idle at random, save in the second half of the random text.
`default_nettype none

module tb_multi_pattern_string_matcher;
    import mpsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        op_t        op;
        logic [4:0] sym;
        logic [7:0] pid;
        logic       restart;
    } cmd_t;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  id;
        logic [31:0] pos;
        logic        last;
    } res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    multi_pattern_string_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Automaton copy held by the bench
    logic [NODE_AW-1:0] trie_next [GOTO_DEPTH];
    logic [PID_W-1:0]   tag_of    [NODES];
    logic [NODE_AW-1:0] fail_of   [NODES];
    logic [NODE_AW-1:0] dict_of   [NODES];
    logic [NODE_AW-1:0] bfs_fifo  [NODES];
    int unsigned        n_nodes;
    logic [NODE_AW-1:0] cursor;
    int unsigned        depth;
    logic [1:0]         fault;
    logic               built;
    logic [NODE_AW-1:0] scan_at;
    logic [31:0]        text_pos;

    cmd_t pending [$];
    res_t awaited [$];
    int   errors;
    int   idle_send;
    int   idle_recv;
    int   cycles;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic res_t status_res(logic [1:0] st);
        res_t r;
        r.kind   = 1'b0;
        r.status = st;
        r.id     = '0;
        r.pos    = '0;
        r.last   = 1'b1;
        return r;
    endfunction

    // Breadth-first pass over the trie: failure, dictionary links, goto fill
    task automatic build_automaton();
        int unsigned        head, tail;
        logic [NODE_AW-1:0] u, fu, v, f;
        head = 0;
        tail = 0;
        for (int i = 0; i < ALPHABET; i++)
        begin
            v = trie_next[i];
            if (v != 0 && tail < NODES)
            begin
                fail_of[v] = '0;
                dict_of[v] = '0;
                bfs_fifo[tail] = v;
                tail++;
            end
        end
        while (head < tail)
        begin
            u = bfs_fifo[head];
            head++;
            fu = fail_of[u];
            for (int i = 0; i < ALPHABET; i++)
            begin
                v = trie_next[u * ALPHABET + i];
                f = trie_next[fu * ALPHABET + i];
                if (v != 0)
                begin
                    fail_of[v] = f;
                    dict_of[v] = (tag_of[f] != 0) ? f : dict_of[f];
                    if (tail < NODES)
                    begin
                        bfs_fifo[tail] = v;
                        tail++;
                    end
                end
                else
                    trie_next[u * ALPHABET + i] = f;
            end
        end
    endtask

    // Predict the transfers caused by one command
    task automatic predict_matches(cmd_t c);
        logic [NODE_AW-1:0] nxt, j;
        int unsigned        n, guard;
        res_t               r;
        case (c.op)
            OP_INSERT:
            begin
                if (built)
                    awaited.push_back(status_res(STS_PHASE));
                else if (fault != 0)
                    awaited.push_back(status_res(fault));
                else if (c.sym >= ALPHABET || depth >= MAX_PATTERN_LEN)
                begin
                    fault = STS_BAD;
                    awaited.push_back(status_res(STS_BAD));
                end
                else
                begin
                    nxt = trie_next[cursor * ALPHABET + c.sym];
                    if (nxt == 0 && n_nodes >= NODES)
                    begin
                        fault = STS_FULL;
                        awaited.push_back(status_res(STS_FULL));
                    end
                    else
                    begin
                        if (nxt == 0)
                        begin
                            nxt = NODE_AW'(n_nodes);
                            n_nodes++;
                            trie_next[cursor * ALPHABET + c.sym] = nxt;
                        end
                        cursor = nxt;
                        depth++;
                        awaited.push_back(status_res(STS_OK));
                    end
                end
            end
            OP_END:
            begin
                if (built)
                    awaited.push_back(status_res(STS_PHASE));
                else
                begin
                    if (fault != 0)
                        awaited.push_back(status_res(fault));
                    else if (depth == 0)
                        awaited.push_back(status_res(STS_BAD));
                    else
                    begin
                        tag_of[cursor] = c.pid;
                        awaited.push_back(status_res(STS_OK));
                    end
                    cursor = '0;
                    depth = 0;
                    fault = '0;
                end
            end
            OP_BUILD:
            begin
                if (built)
                    awaited.push_back(status_res(STS_PHASE));
                else
                begin
                    cursor = '0;
                    depth = 0;
                    fault = '0;
                    build_automaton();
                    built = 1'b1;
                    awaited.push_back(status_res(STS_OK));
                end
            end
            default:
            begin
                if (!built)
                    awaited.push_back(status_res(STS_PHASE));
                else
                begin
                    if (c.restart)
                    begin
                        scan_at = '0;
                        text_pos = '0;
                    end
                    r.kind = 1'b1;
                    r.status = STS_OK;
                    r.pos = text_pos;
                    r.last = 1'b0;
                    text_pos = text_pos + 32'd1;
                    if (c.sym >= ALPHABET)
                        scan_at = '0;
                    else
                    begin
                        j = trie_next[scan_at * ALPHABET + c.sym];
                        scan_at = j;
                        n = 0;
                        guard = 0;
                        while (j != 0 && guard < NODES)
                        begin
                            if (tag_of[j] != 0 && n < MAX_RESULTS)
                            begin
                                r.id = tag_of[j];
                                awaited.push_back(r);
                                n++;
                            end
                            j = dict_of[j];
                            guard++;
                        end
                        if (n > 0)
                            awaited[$].last = 1'b1;
                    end
                end
            end
        endcase
    endtask

    task automatic send(op_t op, int sym, int pid, bit restart);
        cmd_t c;
        c.op = op;
        c.sym = sym[4:0];
        c.pid = pid[7:0];
        c.restart = restart;
        predict_matches(c);
        pending.push_back(c);
    endtask

    // Hold off until every queued command is taken and answered
    task automatic drain();
        while (pending.size() != 0 || s_axis_tvalid || awaited.size() != 0)
            @(posedge clk);
    endtask

    // Driver: present the next command when the slot is free
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t c;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending.size() != 0 && $urandom_range(0, 99) >= idle_send)
            begin
                c = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, c.restart, c.pid, c.sym};
                s_axis_tuser  <= c.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= idle_recv);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t unexpected transfer tuser=%0h tdata=%0h tlast=%0b",
                             $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    errors++;
                end
                else
                begin
                    e = awaited.pop_front();
                    if (m_axis_tuser[0] !== e.kind || m_axis_tdata[1:0] !== e.status
                        || m_axis_tdata[9:2] !== e.id || m_axis_tdata[41:10] !== e.pos
                        || m_axis_tlast !== e.last)
                    begin
                        $display("%0t mismatch expected kind=%0d st=%0d id=%0d pos=%0d last=%0d",
                                 $realtime, e.kind, e.status, e.id, e.pos, e.last);
                        $display("%0t          actual   kind=%0d st=%0d id=%0d pos=%0d last=%0d",
                                 $realtime, m_axis_tuser[0], m_axis_tdata[1:0],
                                 m_axis_tdata[9:2], m_axis_tdata[41:10], m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int len;
        idle_send = 16;
        idle_recv = 52;
        rst_n = 1'b0;
        for (int i = 0; i < GOTO_DEPTH; i++)
            trie_next[i] = '0;
        for (int i = 0; i < NODES; i++)
        begin
            tag_of[i] = '0;
            fail_of[i] = '0;
            dict_of[i] = '0;
        end
        n_nodes = 1;
        cursor = '0;
        depth = 0;
        fault = '0;
        built = 1'b0;
        scan_at = '0;
        text_pos = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: scan before build, empty pattern, bad symbol, id rules
        send(OP_SCAN, 0, 0, 1);
        send(OP_END, 0, 9, 0);
        send(OP_INSERT, 31, 0, 0);
        send(OP_INSERT, 1, 0, 0);
        send(OP_END, 0, 5, 0);
        send(OP_INSERT, 26, 0, 0);
        send(OP_END, 0, 5, 0);
        send(OP_INSERT, 25, 0, 0);
        send(OP_INSERT, 24, 0, 0);
        send(OP_END, 0, 255, 0);
        send(OP_INSERT, 25, 0, 0);
        send(OP_INSERT, 24, 0, 0);
        send(OP_END, 0, 170, 0);
        send(OP_INSERT, 24, 0, 0);
        send(OP_END, 0, 0, 0);
        send(OP_INSERT, 2, 0, 0);
        send(OP_INSERT, 3, 0, 0);
        send(OP_END, 0, 85, 0);

        // Short chain of nested a-patterns
        for (int k = 1; k <= 5; k++)
        begin
            for (int s = 0; s < k; s++)
                send(OP_INSERT, 0, 0, 0);
            send(OP_END, 0, k, 0);
        end

        // One pattern of a's whose 33rd symbol is too long
        for (int s = 0; s < 33; s++)
            send(OP_INSERT, 0, 0, 0);
        send(OP_END, 0, 99, 0);

        // Overlapping patterns over a few letters, with some noise
        for (int p = 0; p < 10; p++)
        begin
            len = $urandom_range(1, 6);
            for (int s = 0; s < len; s++)
                send(OP_INSERT, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(0, 3), 0, 0);
            send(OP_END, 0, $urandom_range(0, 255), 0);
        end
        drain();

        // Build with a pattern still open, then the wrong-phase cases
        send(OP_INSERT, 1, 0, 0);
        send(OP_INSERT, 2, 0, 0);
        send(OP_BUILD, 0, 0, 0);
        send(OP_BUILD, 0, 0, 0);
        send(OP_INSERT, 0, 0, 0);
        send(OP_END, 0, 1, 0);
        drain();

        // Chain of a's: several matches on one symbol
        idle_send = 52;
        idle_recv = 16;
        send(OP_SCAN, 0, $urandom_range(0, 255), 1);
        for (int s = 0; s < 10; s++)
            send(OP_SCAN, 0, $urandom_range(0, 255), 0);
        send(OP_SCAN, 25, 0, 1);
        send(OP_SCAN, 24, 0, 0);
        send(OP_SCAN, 2, 0, 0);
        send(OP_SCAN, 3, 0, 0);

        // Random text
        for (int t = 0; t < 90; t++)
        begin
            if (t == 45)
            begin
                drain();
                idle_send = 0;
                idle_recv = 0;
            end
            send(OP_SCAN, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) :
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) :
                          $urandom_range(0, 3),
                 $urandom_range(0, 255), $urandom_range(0, 24) == 0);
        end
        drain();
        repeat (300) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/mpsm_pkg.sv
hw/rtl/multi_pattern_string_matcher.sv
sim/tb_multi_pattern_string_matcher.sv
